// File: design/ntpm_pkg.sv
// Shared types and constants for the nearest timestamp pair matcher.
// Depends on nothing; the core, the gap unit and the testbench import it.
package ntpm_pkg;

    localparam int STAMP_W = 63;
    localparam int TAG_W   = 16;
    localparam int GAP_W   = 30;

    localparam int IMAGE_DEPTH_DEF = 16;
    localparam int LIDAR_DEPTH_DEF = 8;
    localparam int TAG_BITS_DEF    = 16;

    localparam int RESULT_CAP = 8;
    localparam int NCNT_W     = $clog2(RESULT_CAP + 1);

    localparam logic [GAP_W-1:0] THRESHOLD_RESET = 30'd226650000;
    localparam logic [GAP_W-1:0] SEARCH_WINDOW   = 30'd1000000000;

    typedef struct packed {
        logic               mode;
        logic [STAMP_W-1:0] stamp_ns;
        logic [TAG_W-1:0]   item_tag;
    } ntpm_in_t;

    typedef struct packed {
        logic [TAG_W-1:0] image_tag;
        logic [TAG_W-1:0] lidar_tag;
        logic [GAP_W-1:0] gap_ns;
        logic             last_pair;
    } ntpm_out_t;

endpackage

// File: design/nearest_timestamp_pair_matcher_core.sv
// Nearest timestamp pair matcher: pairs lidar sweeps with camera images by stamp.
// Sequence: accept in IDLE, then per pair attempt LOOK, SCAN and DECIDE
// (the image RAM is read one entry a cycle through the shared gap unit), then FLUSH.
// A new item is taken only in IDLE, once the last one is fully handled; output stalls
// can hold the core in DECIDE or FLUSH.
// Reset: queues empty, threshold 226650000 ns; queue RAM contents are not cleared.
// Depends on ntpm_pkg, ntpm_ram and ntpm_gap_unit.
module nearest_timestamp_pair_matcher_core
    import ntpm_pkg::*;
#(
    parameter int IMAGE_DEPTH = IMAGE_DEPTH_DEF,
    parameter int LIDAR_DEPTH = LIDAR_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ntpm_in_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output ntpm_out_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [GAP_W-1:0] cfg_data
);

    localparam int IA = $clog2(IMAGE_DEPTH);
    localparam int LA = (LIDAR_DEPTH > 1) ? $clog2(LIDAR_DEPTH) : 1;
    localparam int IC = $clog2(IMAGE_DEPTH + 1);
    localparam int LC = $clog2(LIDAR_DEPTH + 1);
    localparam int WW = STAMP_W + TAG_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOK   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    function automatic logic [IA-1:0] img_wrap(input logic [IA:0] s);
        logic [IA:0] t;
        t = s - (IA + 1)'(IMAGE_DEPTH);
        return (s >= (IA + 1)'(IMAGE_DEPTH)) ? t[IA-1:0] : s[IA-1:0];
    endfunction

    function automatic logic [LA-1:0] lid_wrap(input logic [LA:0] s);
        logic [LA:0] t;
        t = s - (LA + 1)'(LIDAR_DEPTH);
        return (s >= (LA + 1)'(LIDAR_DEPTH)) ? t[LA-1:0] : s[LA-1:0];
    endfunction

    logic [2:0]        state_reg,    state_next;
    logic [GAP_W-1:0]  thr_reg,      thr_next;
    logic [IA-1:0]     img_head_reg, img_head_next;
    logic [IC-1:0]     img_cnt_reg,  img_cnt_next;
    logic [LA-1:0]     lid_head_reg, lid_head_next;
    logic [LC-1:0]     lid_cnt_reg,  lid_cnt_next;
    logic [NCNT_W-1:0] n_reg,        n_next;
    logic [IC-1:0]     k_reg,        k_next;
    logic [IC-1:0]     dk_reg,       dk_next;
    logic              dv_reg,       dv_next;
    logic [GAP_W-1:0]  best_reg,     best_next;
    logic [IC-1:0]     bidx_reg,     bidx_next;
    logic [TAG_BITS-1:0] btag_reg,   btag_next;
    logic              found_reg,    found_next;
    logic              pend_valid_reg, pend_valid_next;
    ntpm_out_t         pend_reg,     pend_next;
    logic              out_valid_reg, out_valid_next;
    ntpm_out_t         out_reg,      out_next;

    logic              accept;
    logic              issue;
    logic              out_free;
    logic              match;
    logic              img_full;
    logic              lid_full;
    logic [IA-1:0]     img_slot;
    logic [LA-1:0]     lid_slot;
    logic [IA-1:0]     img_rd_addr;
    logic [WW-1:0]     in_word;
    logic [WW-1:0]     img_rd;
    logic [WW-1:0]     lid_rd;
    logic [GAP_W-1:0]  gu_gap;
    logic              gu_better;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign issue    = (state_reg == ST_SCAN) && (k_reg < img_cnt_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign match    = found_reg && (best_reg < thr_reg);
    assign in_word  = {in_data.stamp_ns, TAG_BITS'(in_data.item_tag)};

    assign img_full = (img_cnt_reg == IC'(IMAGE_DEPTH));
    assign lid_full = (lid_cnt_reg == LC'(LIDAR_DEPTH));
    // A full queue overwrites its oldest entry, which sits at the head.
    assign img_slot = img_full ? img_head_reg
                               : img_wrap({1'b0, img_head_reg} + (IA + 1)'(img_cnt_reg));
    assign lid_slot = lid_full ? lid_head_reg
                               : lid_wrap({1'b0, lid_head_reg} + (LA + 1)'(lid_cnt_reg));
    assign img_rd_addr = img_wrap({1'b0, img_head_reg} + (IA + 1)'(k_reg));

    ntpm_ram #(
        .WIDTH (WW),
        .DEPTH (IMAGE_DEPTH)
    ) u_img_ram (
        .clk     (clk),
        .wr_en   (accept && !in_data.mode),
        .wr_addr (img_slot),
        .wr_data (in_word),
        .rd_en   (issue),
        .rd_addr (img_rd_addr),
        .rd_data (img_rd)
    );

    ntpm_ram #(
        .WIDTH (WW),
        .DEPTH (LIDAR_DEPTH)
    ) u_lid_ram (
        .clk     (clk),
        .wr_en   (accept && in_data.mode),
        .wr_addr (lid_slot),
        .wr_data (in_word),
        .rd_en   (state_reg == ST_LOOK),
        .rd_addr (lid_head_reg),
        .rd_data (lid_rd)
    );

    ntpm_gap_unit u_gap (
        .lidar_stamp (lid_rd[WW-1:TAG_BITS]),
        .image_stamp (img_rd[WW-1:TAG_BITS]),
        .best        (best_reg),
        .gap         (gu_gap),
        .better      (gu_better)
    );

    always_comb
    begin
        state_next      = state_reg;
        thr_next        = thr_reg;
        img_head_next   = img_head_reg;
        img_cnt_next    = img_cnt_reg;
        lid_head_next   = lid_head_reg;
        lid_cnt_next    = lid_cnt_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        dk_next         = dk_reg;
        dv_next         = 1'b0;
        best_next       = best_reg;
        bidx_next       = bidx_reg;
        btag_next       = btag_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_stall ? out_valid_reg : 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            thr_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next = '0;
                    if (in_data.mode)
                    begin
                        if (lid_full)
                        begin
                            lid_head_next = lid_wrap({1'b0, lid_head_reg} + (LA + 1)'(1));
                        end
                        else
                        begin
                            lid_cnt_next = lid_cnt_reg + LC'(1);
                        end
                    end
                    else
                    begin
                        if (img_full)
                        begin
                            img_head_next = img_wrap({1'b0, img_head_reg} + (IA + 1)'(1));
                        end
                        else
                        begin
                            img_cnt_next = img_cnt_reg + IC'(1);
                        end
                    end
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                k_next     = '0;
                best_next  = SEARCH_WINDOW;
                found_next = 1'b0;
                if ((lid_cnt_reg != '0) && (img_cnt_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_SCAN:
            begin
                // Reads are issued one image per cycle; the compare follows in the cycle after each read.
                if (issue)
                begin
                    k_next = k_reg + IC'(1);
                end
                dv_next = issue;
                dk_next = k_reg;
                if (dv_reg && gu_better)
                begin
                    best_next  = gu_gap;
                    bidx_next  = dk_reg;
                    btag_next  = img_rd[TAG_BITS-1:0];
                    found_next = 1'b1;
                end
                if (!issue && !dv_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!match)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // The held pair is not the last one, since another pair follows it.
                    if (pend_valid_reg)
                    begin
                        out_next           = pend_reg;
                        out_next.last_pair = 1'b0;
                        out_valid_next     = 1'b1;
                    end
                    pend_valid_next     = 1'b1;
                    pend_next.image_tag = TAG_W'(btag_reg);
                    pend_next.lidar_tag = TAG_W'(lid_rd[TAG_BITS-1:0]);
                    pend_next.gap_ns    = best_reg;
                    pend_next.last_pair = 1'b0;
                    img_head_next = img_wrap({1'b0, img_head_reg} + (IA + 1)'(bidx_reg));
                    img_cnt_next  = img_cnt_reg - bidx_reg;
                    lid_head_next = lid_wrap({1'b0, lid_head_reg} + (LA + 1)'(1));
                    lid_cnt_next  = lid_cnt_reg - LC'(1);
                    n_next        = n_reg + NCNT_W'(1);
                    if (n_reg + NCNT_W'(1) == NCNT_W'(RESULT_CAP))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next           = pend_reg;
                    out_next.last_pair = 1'b1;
                    out_valid_next     = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THRESHOLD_RESET;
            img_head_reg   <= '0;
            img_cnt_reg    <= '0;
            lid_head_reg   <= '0;
            lid_cnt_reg    <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            dv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            img_head_reg   <= img_head_next;
            img_cnt_reg    <= img_cnt_next;
            lid_head_reg   <= lid_head_next;
            lid_cnt_reg    <= lid_cnt_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            dv_reg         <= dv_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dk_reg   <= dk_next;
        best_reg <= best_next;
        bidx_reg <= bidx_next;
        btag_reg <= btag_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pair left pending while idle");

    a_img_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        img_cnt_reg <= IC'(IMAGE_DEPTH))
        else $error("image queue count exceeds its depth");

    a_lid_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lid_cnt_reg <= LC'(LIDAR_DEPTH))
        else $error("lidar queue count exceeds its depth");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && match && n_reg == NCNT_W'(RESULT_CAP - 1)
         && (!pend_valid_reg || out_free)) |=> (state_reg == ST_FLUSH))
        else $error("pair count passed its cap");

endmodule

// File: design/ntpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ntpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/ntpm_gap_unit.sv
// Shared gap unit: absolute stamp difference and compare against the running best.
// Depends on ntpm_pkg.
module ntpm_gap_unit
    import ntpm_pkg::*;
(
    input  logic [STAMP_W-1:0] lidar_stamp,
    input  logic [STAMP_W-1:0] image_stamp,
    input  logic [GAP_W-1:0]   best,
    output logic [GAP_W-1:0]   gap,
    output logic               better
);

    logic [STAMP_W:0]   diff_li;
    logic [STAMP_W:0]   diff_il;
    logic [STAMP_W-1:0] mag;
    logic               near;

    always_comb
    begin
        diff_li = {1'b0, lidar_stamp} - {1'b0, image_stamp};
        diff_il = {1'b0, image_stamp} - {1'b0, lidar_stamp};
        // A borrow means the image is later than the sweep.
        mag     = diff_li[STAMP_W] ? diff_il[STAMP_W-1:0] : diff_li[STAMP_W-1:0];
        near    = (mag[STAMP_W-1:GAP_W] == '0);
        gap     = mag[GAP_W-1:0];
        // The best value never exceeds the search window, so only narrow gaps can win.
        better  = near && (gap < best);
    end

endmodule

// File: verif/tb_nearest_timestamp_pair_matcher_core.sv
// Self-checking testbench for nearest_timestamp_pair_matcher_core: directed and random
// camera/lidar streams, checked against an in-bench model of the pairing queues.
// Depends on ntpm_pkg and the design files of the core.
module tb_nearest_timestamp_pair_matcher_core
    import ntpm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_IMAGE = 1'b0;
    localparam logic MODE_LIDAR = 1'b1;

    localparam int unsigned RANDOM_ITEMS   = 330;
    localparam int unsigned HOLD_CYCLES    = 700;
    localparam int unsigned DRAIN_PAUSE    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 6000;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam logic [STAMP_W-1:0] CAP_BASE  = 63'd5_000_000_000_000;
    localparam logic [STAMP_W-1:0] WIN_BASE  = 63'd40_000_000_000;

    class sync_pair_tracker;
        logic [STAMP_W-1:0] img_stamp [IMAGE_DEPTH_DEF];
        logic [TAG_W-1:0]   img_tag   [IMAGE_DEPTH_DEF];
        logic [STAMP_W-1:0] lid_stamp [LIDAR_DEPTH_DEF];
        logic [TAG_W-1:0]   lid_tag   [LIDAR_DEPTH_DEF];
        int unsigned        img_head, img_count, lid_head, lid_count;
        logic [GAP_W-1:0]   threshold;
        ntpm_out_t          pairs_due [$];
        int unsigned        pairs_seen;
        int unsigned        mismatches;

        function new();
            threshold  = THRESHOLD_RESET;
            img_head   = 0;
            img_count  = 0;
            lid_head   = 0;
            lid_count  = 0;
            pairs_seen = 0;
            mismatches = 0;
        endfunction

        function void set_threshold(logic [GAP_W-1:0] value);
            threshold = value;
        endfunction

        function int unsigned pending();
            return pairs_due.size();
        endfunction

        // Queue the arriving item, then pair head sweeps for as long as they match, up to RESULT_CAP pairs.
        function void take_item(ntpm_in_t item);
            logic [STAMP_W-1:0] lid_t, img_t, diff;
            logic [63:0]        best;
            int unsigned        k, best_k, slot, made;
            bit                 found;
            ntpm_out_t          pair;
            if (item.mode == MODE_LIDAR) begin
                if (lid_count == LIDAR_DEPTH_DEF) begin
                    lid_head = (lid_head + 1) % LIDAR_DEPTH_DEF;
                    lid_count--;
                end
                slot = (lid_head + lid_count) % LIDAR_DEPTH_DEF;
                lid_stamp[slot] = item.stamp_ns;
                lid_tag[slot]   = item.item_tag;
                lid_count++;
            end
            else begin
                if (img_count == IMAGE_DEPTH_DEF) begin
                    img_head = (img_head + 1) % IMAGE_DEPTH_DEF;
                    img_count--;
                end
                slot = (img_head + img_count) % IMAGE_DEPTH_DEF;
                img_stamp[slot] = item.stamp_ns;
                img_tag[slot]   = item.item_tag;
                img_count++;
            end
            made = 0;
            while (made < RESULT_CAP && lid_count > 0 && img_count > 0) begin
                lid_t  = lid_stamp[lid_head];
                best   = 64'(SEARCH_WINDOW);
                best_k = 0;
                found  = 1'b0;
                for (k = 0; k < img_count; k++) begin
                    img_t = img_stamp[(img_head + k) % IMAGE_DEPTH_DEF];
                    diff  = (lid_t > img_t) ? lid_t - img_t : img_t - lid_t;
                    if (64'(diff) < best) begin
                        best   = 64'(diff);
                        best_k = k;
                        found  = 1'b1;
                    end
                end
                if (!found || best >= 64'(threshold))
                    break;
                // Older images go, the matched one stays at the head for later sweeps.
                img_head  = (img_head + best_k) % IMAGE_DEPTH_DEF;
                img_count = img_count - best_k;
                pair.image_tag = img_tag[img_head];
                pair.lidar_tag = lid_tag[lid_head];
                pair.gap_ns    = best[GAP_W-1:0];
                pair.last_pair = 1'b0;
                pairs_due = {pairs_due, pair};
                made++;
                lid_head = (lid_head + 1) % LIDAR_DEPTH_DEF;
                lid_count--;
            end
            if (made > 0)
                pairs_due[pairs_due.size() - 1].last_pair = 1'b1;
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        task check_pair(ntpm_out_t got);
            ntpm_out_t want;
            string     bad;
            pairs_seen++;
            if (pairs_due.size() == 0) begin
                report($sformatf("pair %0d unexpected: image %h lidar %h gap %0d last %b",
                                 pairs_seen, got.image_tag, got.lidar_tag, got.gap_ns,
                                 got.last_pair));
                return;
            end
            want = pairs_due.pop_front();
            bad  = "";
            if (got.image_tag !== want.image_tag) bad = {bad, " image_tag"};
            if (got.lidar_tag !== want.lidar_tag) bad = {bad, " lidar_tag"};
            if (got.gap_ns !== want.gap_ns)       bad = {bad, " gap_ns"};
            if (got.last_pair !== want.last_pair) bad = {bad, " last_pair"};
            if (bad != "")
                report($sformatf("pair %0d wrong%s: got %h/%h/%0d/%b, want %h/%h/%0d/%b",
                                 pairs_seen, bad, got.image_tag, got.lidar_tag, got.gap_ns,
                                 got.last_pair, want.image_tag, want.lidar_tag,
                                 want.gap_ns, want.last_pair));
        endtask
    endclass

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    ntpm_in_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    ntpm_out_t        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [GAP_W-1:0] cfg_data  = '0;

    sync_pair_tracker tracker;
    bit               calm       = 1'b0;
    bit               hold_req   = 1'b0;
    int unsigned      items_sent = 0;

    nearest_timestamp_pair_matcher_core #(
        .IMAGE_DEPTH(IMAGE_DEPTH_DEF),
        .LIDAR_DEPTH(LIDAR_DEPTH_DEF),
        .TAG_BITS   (TAG_BITS_DEF)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned pick_idle();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic [STAMP_W-1:0] random_stamp();
        return STAMP_W'({$urandom, $urandom});
    endfunction

    task automatic send(input logic mode, input logic [STAMP_W-1:0] stamp,
                        input logic [TAG_W-1:0] tag);
        ntpm_in_t    item;
        int unsigned idle;
        item.mode     = mode;
        item.stamp_ns = stamp;
        item.item_tag = tag;
        idle = pick_idle();
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic write_threshold(input logic [GAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_threshold(value);
    endtask

    // Stop offering beats, wait for every predicted pair, then give the core time to
    // finish any item that produces nothing.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Interleaved camera and lidar traffic around a random base time, with jitter,
    // lidar arrival lag and a sprinkling of unrelated items.
    task automatic run_stream(input int unsigned count, input int unsigned img_period_max);
        logic [STAMP_W-1:0] base;
        longint unsigned    img_off, lid_off, lag;
        int unsigned        img_period, lid_period;
        logic [TAG_W-1:0]   img_tag, lid_tag;
        base       = random_stamp();
        img_off    = $urandom_range(0, 20_000_000);
        lid_off    = $urandom_range(0, 20_000_000);
        img_period = $urandom_range(5_000_000, img_period_max);
        lid_period = $urandom_range(img_period, 3 * img_period);
        lag        = 0;
        img_tag    = TAG_W'($urandom);
        lid_tag    = TAG_W'($urandom);
        repeat (count)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                send(1'($urandom_range(0, 1)), random_stamp(), TAG_W'($urandom));
            end
            else if (lid_off + lag < img_off)
            begin
                send(MODE_LIDAR, STAMP_W'(base + lid_off), lid_tag);
                lid_tag++;
                lid_off = lid_off + lid_period + $urandom_range(0, lid_period / 4)
                          - lid_period / 8;
                lag = $urandom_range(0, 2 * img_period);
            end
            else
            begin
                send(MODE_IMAGE, STAMP_W'(base + img_off), img_tag);
                img_tag++;
                img_off = img_off + img_period + $urandom_range(0, img_period / 4)
                          - img_period / 8;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.take_item(in_data);
        if (rst_n && out_valid && !out_stall)
            tracker.check_pair(out_data);
    end

    // Result side: free-running stretches, random stalls, and one long hold on request.
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (calm || $urandom_range(0, 2) != 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (pick_idle() + 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int unsigned        start, chunk, n;
        logic [STAMP_W-1:0] base;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold: exact hit, gap equal to the threshold, one below it.
        send(MODE_IMAGE, '0, '0);
        send(MODE_LIDAR, '0, '1);
        send(MODE_LIDAR, STAMP_W'(THRESHOLD_RESET), 16'h0001);
        send(MODE_IMAGE, STAMP_W'(THRESHOLD_RESET) * 2 - 1, 16'h7FFE);
        // Two images equally far from the sweep: the older one wins.
        send(MODE_IMAGE, 63'd9_999_999_950, 16'h0002);
        send(MODE_IMAGE, 63'd10_000_000_050, 16'h0003);
        send(MODE_LIDAR, 63'd10_000_000_000, 16'h8004);
        send(MODE_IMAGE, STAMP_MAX, 16'hFFFF);
        send(MODE_LIDAR, STAMP_MAX - 3, 16'h0005);
        // Nine waiting sweeps overflow the lidar queue; one image then pairs the full cap.
        for (n = 0; n < 9; n++)
            send(MODE_LIDAR, CAP_BASE + n * 1000, TAG_W'(16'h0100 + n));
        send(MODE_IMAGE, CAP_BASE + 4500, 16'hA5A5);

        settle();
        write_threshold(GAP_W'(1));
        base = random_stamp();
        send(MODE_IMAGE, base, 16'h0300);
        send(MODE_LIDAR, base, 16'h0301);
        send(MODE_LIDAR, base + 1, 16'h0302);
        send(MODE_IMAGE, base + 1, 16'h0303);

        // Widest threshold: a gap of exactly the search window still never pairs.
        settle();
        write_threshold(SEARCH_WINDOW);
        send(MODE_IMAGE, WIN_BASE, 16'h5A5A);
        send(MODE_LIDAR, WIN_BASE + 63'd1_000_000_000, 16'h0200);
        send(MODE_IMAGE, WIN_BASE + 63'd1_999_999_999, 16'h0201);
        run_stream(40, 900_000_000);

        settle();
        write_threshold('0);
        run_stream(30, 100_000_000);

        settle();
        write_threshold(THRESHOLD_RESET);
        start = items_sent;
        chunk = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            chunk++;
            n    = $urandom_range(8, 40);
            calm = ($urandom_range(0, 3) == 0);
            if (chunk % 5 == 0)
            begin
                settle();
                write_threshold(GAP_W'($urandom_range(10_000_000, 1_000_000_000)));
            end
            // One chunk runs into a long result hold so the core backs up its input.
            if (chunk == 3)
            begin
                calm     = 1'b1;
                hold_req = 1'b1;
                n        = 60;
            end
            if ($urandom_range(0, 7) == 0)
                repeat (n) send(1'($urandom_range(0, 1)), random_stamp(), TAG_W'($urandom));
            else
                run_stream(n, $urandom_range(10_000_000, 300_000_000));
        end
        calm = 1'b0;
        settle();

        if (tracker.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
